>>> src/lfss_pkg.sv
// Shared types, widths, register indexes and constant arithmetic for the line-follow speed/steer block.
package lfss_pkg;

   localparam int POS_W   = 10;
   localparam int MAG_W   = 10;
   localparam int CURV_W  = 27;
   localparam int SPEED_W = 17;
   localparam int BASE_W  = 20;
   localparam int SPD_W   = 10;
   localparam int RATE_W  = 16;
   localparam int WIN_W   = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W  = 25;
   localparam int QUOT_W  = 16;

   // Reciprocal of 1000 scaled by 2^35, rounded up: exact for dividends below 2^25.
   localparam int DIV_SHIFT = 35;
   localparam int DIV_MUL_W = 26;
   localparam logic [DIV_MUL_W-1:0] DIV_MUL = 26'd34359739;

   localparam logic [BASE_W-1:0] MILLI = 20'd1000;
   localparam logic signed [CURV_W-1:0] CURV_OFFSET = 27'sd1000;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SPEED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_RATE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_RATE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_GAIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_GAIN     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_WINDOW = 3'd7;

   // Register reset values
   localparam logic [SPD_W-1:0]  RST_INITIAL_SPEED = 10'd80;
   localparam logic [SPD_W-1:0]  RST_MAX_SPEED     = 10'd100;
   localparam logic [SPD_W-1:0]  RST_MIN_SPEED     = 10'd80;
   localparam logic [RATE_W-1:0] RST_RISE_RATE     = 16'd100;
   localparam logic [RATE_W-1:0] RST_FALL_RATE     = 16'd200;
   localparam logic [RATE_W-1:0] RST_STEER_GAIN    = 16'd300;
   localparam logic [RATE_W-1:0] RST_SLOW_GAIN     = 16'd500;
   localparam logic [WIN_W-1:0]  RST_CENTRE_WINDOW = 9'd20;
   localparam logic [BASE_W-1:0] RST_BASE          = 20'd80000;

   typedef struct packed {
      logic [SPD_W-1:0]  initial_speed;
      logic [SPD_W-1:0]  max_speed;
      logic [SPD_W-1:0]  min_speed;
      logic [RATE_W-1:0] rise_rate;
      logic [RATE_W-1:0] fall_rate;
      logic [RATE_W-1:0] steer_gain;
      logic [RATE_W-1:0] slow_gain;
      logic [WIN_W-1:0]  centre_window;
   } cfg_type;

   typedef struct packed {
      logic             fire;
      logic             restart;
      logic [MAG_W-1:0] mag;
   } step_type;

   // Truncating divide by 1000 through the scaled reciprocal.
   function automatic logic [QUOT_W-1:0] div1000(input logic [PROD_W-1:0] x);
      logic [PROD_W+DIV_MUL_W-1:0] p;
      p = (PROD_W+DIV_MUL_W)'(x) * (PROD_W+DIV_MUL_W)'(DIV_MUL);
      return p[DIV_SHIFT +: QUOT_W];
   endfunction

endpackage

>>> src/lfss_if.sv
// Valid/ready channel interfaces for the request and response transactions.
interface lfss_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic signed [lfss_pkg::POS_W-1:0]   position;

   modport source (output valid, mode, position, input ready);
   modport sink   (input valid, mode, position, output ready);
endinterface

interface lfss_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lfss_pkg::CURV_W-1:0]  curvature;
   logic signed [lfss_pkg::SPEED_W-1:0] speed;

   modport source (output valid, curvature, speed, input ready);
   modport sink   (input valid, curvature, speed, output ready);
endinterface

>>> src/line_follow_speed_steer_top.sv
// Top level of the line-follow speed and steering block.
// Each tracking transaction carries one signed line position and yields one response with a
// steering curvature (-position*steer_gain - 1000) and a speed command (base speed in whole
// units minus |position|*slow_gain/1000, both divides truncating). The base speed is kept in
// thousandths; a centred position (|position| below centre_window) raises it by rise_rate up
// to max_speed*1000, any other position lowers it by fall_rate down to min_speed*1000. A
// restart transaction (mode 1) reloads initial_speed*1000 and produces no response. The block
// takes one transaction per cycle while the response side does not stall it. It passes
// through three registers: the input register, then base update and multiplies, then divide
// by 1000 and subtract. rsp valid is the third register, so the earliest response handshake
// follows the input and stage-2 registers. The base speed register closes its update loop
// through itself alone, which is what allows the one-per-cycle rate. Registers are written through
// csr_wr_en/csr_index/csr_wdata and should only change while no transaction is in flight.
module line_follow_speed_steer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   lfss_req_if.sink                             req_ch,
   lfss_rsp_if.source                           rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [lfss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lfss_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // ---------------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------------
   lfss_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_speed <= lfss_pkg::RST_INITIAL_SPEED;
         cfg_ff.max_speed     <= lfss_pkg::RST_MAX_SPEED;
         cfg_ff.min_speed     <= lfss_pkg::RST_MIN_SPEED;
         cfg_ff.rise_rate     <= lfss_pkg::RST_RISE_RATE;
         cfg_ff.fall_rate     <= lfss_pkg::RST_FALL_RATE;
         cfg_ff.steer_gain    <= lfss_pkg::RST_STEER_GAIN;
         cfg_ff.slow_gain     <= lfss_pkg::RST_SLOW_GAIN;
         cfg_ff.centre_window <= lfss_pkg::RST_CENTRE_WINDOW;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            lfss_pkg::CSR_INITIAL_SPEED: begin
               cfg_ff.initial_speed <= csr_wdata[lfss_pkg::SPD_W-1:0];
            end
            lfss_pkg::CSR_MAX_SPEED: begin
               cfg_ff.max_speed <= csr_wdata[lfss_pkg::SPD_W-1:0];
            end
            lfss_pkg::CSR_MIN_SPEED: begin
               cfg_ff.min_speed <= csr_wdata[lfss_pkg::SPD_W-1:0];
            end
            lfss_pkg::CSR_RISE_RATE: begin
               cfg_ff.rise_rate <= csr_wdata[lfss_pkg::RATE_W-1:0];
            end
            lfss_pkg::CSR_FALL_RATE: begin
               cfg_ff.fall_rate <= csr_wdata[lfss_pkg::RATE_W-1:0];
            end
            lfss_pkg::CSR_STEER_GAIN: begin
               cfg_ff.steer_gain <= csr_wdata[lfss_pkg::RATE_W-1:0];
            end
            lfss_pkg::CSR_SLOW_GAIN: begin
               cfg_ff.slow_gain <= csr_wdata[lfss_pkg::RATE_W-1:0];
            end
            lfss_pkg::CSR_CENTRE_WINDOW: begin
               cfg_ff.centre_window <= csr_wdata[lfss_pkg::WIN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // Pipeline advance: each stage moves when it is empty or the stage after it moves, so
   // bubbles collapse and a waiting response never blocks a new request on its own.
   // ---------------------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff;
   logic out_en, s2_en, s1_en;

   assign out_en = !out_valid_ff || rsp_ch.ready;
   assign s2_en  = !s2_valid_ff || out_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   assign req_ch.ready = s1_en;

   // ---------------------------------------------------------------------------------------
   // Stage 1: capture the request transaction
   // ---------------------------------------------------------------------------------------
   logic                                s1_mode_ff;
   logic signed [lfss_pkg::POS_W-1:0]   s1_pos_ff;
   logic [lfss_pkg::MAG_W-1:0]          s1_mag;

   assign s1_valid_in = req_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_mode_ff <= req_ch.mode;
         s1_pos_ff  <= req_ch.position;
      end
   end

   // Magnitude fits unsigned in the same width: the most negative position maps to 512.
   assign s1_mag = s1_pos_ff[lfss_pkg::POS_W-1] ? lfss_pkg::MAG_W'(-s1_pos_ff)
                                                : lfss_pkg::MAG_W'(s1_pos_ff);

   // ---------------------------------------------------------------------------------------
   // Stage 2 inputs: base speed update, steering and slowdown products
   // ---------------------------------------------------------------------------------------
   lfss_pkg::step_type                  step;
   logic [lfss_pkg::BASE_W-1:0]         base_next;
   logic signed [lfss_pkg::CURV_W-1:0]  steer_prod;
   logic signed [lfss_pkg::CURV_W-1:0]  curv_in;
   logic [lfss_pkg::PROD_W-1:0]         slow_prod_in;

   // Advance the base speed only when the stage-1 transaction actually moves on.
   assign step.fire    = s1_valid_ff && s2_en;
   assign step.restart = s1_mode_ff;
   assign step.mag     = s1_mag;

   lfss_base_speed u_base (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .base_next (base_next)
   );

   always_comb begin
      steer_prod   = lfss_pkg::CURV_W'(s1_pos_ff)
                     * lfss_pkg::CURV_W'($signed({1'b0, cfg_ff.steer_gain}));
      curv_in      = -steer_prod - lfss_pkg::CURV_OFFSET;
      slow_prod_in = lfss_pkg::PROD_W'(s1_mag) * lfss_pkg::PROD_W'(cfg_ff.slow_gain);
   end

   // Restart transactions drop out here: no response.
   assign s2_valid_in = s1_valid_ff && !s1_mode_ff;

   logic [lfss_pkg::BASE_W-1:0]         s2_base_ff;
   logic signed [lfss_pkg::CURV_W-1:0]  s2_curv_ff;
   logic [lfss_pkg::PROD_W-1:0]         s2_slow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_base_ff <= base_next;
         s2_curv_ff <= curv_in;
         s2_slow_ff <= slow_prod_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 3: divide both terms by 1000 and form the speed command
   // ---------------------------------------------------------------------------------------
   logic [lfss_pkg::QUOT_W-1:0]         base_units;
   logic [lfss_pkg::QUOT_W-1:0]         slow_units;
   logic signed [lfss_pkg::SPEED_W-1:0] speed_in;

   always_comb begin
      base_units = lfss_pkg::div1000(lfss_pkg::PROD_W'(s2_base_ff));
      slow_units = lfss_pkg::div1000(s2_slow_ff);
      speed_in   = $signed(lfss_pkg::SPEED_W'(base_units) - lfss_pkg::SPEED_W'(slow_units));
   end

   logic signed [lfss_pkg::CURV_W-1:0]  out_curv_ff;
   logic signed [lfss_pkg::SPEED_W-1:0] out_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_curv_ff  <= s2_curv_ff;
         out_speed_ff <= speed_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.curvature = out_curv_ff;
   assign rsp_ch.speed     = out_speed_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   // A restart leaving stage 1 never produces a stage-2 entry.
   a_restart_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_mode_ff && s2_en) |=> !s2_valid_ff)
      else $error("restart transaction produced a response entry");

   // The stored base speed never exceeds 1023 whole units.
   a_base_bound: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_base_ff <= 20'd1023000))
      else $error("base speed out of range");

   // Reset empties the whole pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff && !out_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

>>> src/lfss_base_speed.sv
// Base speed register with rise/fall clamping and restart reload.
module lfss_base_speed (
   input  logic                            clock,
   input  logic                            reset,
   input  lfss_pkg::cfg_type               cfg,
   input  lfss_pkg::step_type              step,
   output logic [lfss_pkg::BASE_W-1:0]     base_next
);

   logic [lfss_pkg::BASE_W-1:0] base_ff;
   logic [lfss_pkg::BASE_W-1:0] base_in;
   logic [lfss_pkg::BASE_W-1:0] top_milli;
   logic [lfss_pkg::BASE_W-1:0] bottom_milli;
   logic [lfss_pkg::BASE_W-1:0] init_milli;
   logic [lfss_pkg::BASE_W:0]   inc_sum;
   logic [lfss_pkg::BASE_W:0]   dec_floor;
   logic                        centred;

   always_comb begin
      top_milli    = lfss_pkg::BASE_W'(cfg.max_speed) * lfss_pkg::MILLI;
      bottom_milli = lfss_pkg::BASE_W'(cfg.min_speed) * lfss_pkg::MILLI;
      init_milli   = lfss_pkg::BASE_W'(cfg.initial_speed) * lfss_pkg::MILLI;
      inc_sum      = {1'b0, base_ff} + (lfss_pkg::BASE_W+1)'(cfg.rise_rate);
      // base - fall < bottom  <=>  base < fall + bottom
      dec_floor    = {1'b0, bottom_milli} + (lfss_pkg::BASE_W+1)'(cfg.fall_rate);
      centred      = step.mag < lfss_pkg::MAG_W'(cfg.centre_window);

      base_in = base_ff;
      if (step.fire) begin
         if (step.restart) begin
            base_in = init_milli;
         end else if (centred) begin
            base_in = (inc_sum > {1'b0, top_milli}) ? top_milli
                                                    : inc_sum[lfss_pkg::BASE_W-1:0];
         end else begin
            base_in = ({1'b0, base_ff} < dec_floor) ? bottom_milli
                      : base_ff - lfss_pkg::BASE_W'(cfg.fall_rate);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= lfss_pkg::RST_BASE;
      end else begin
         base_ff <= base_in;
      end
   end

   assign base_next = base_in;

endmodule
